@@ rtl/bcrlo_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcrlo_pkg
// Types, opcodes and GF(2^8) helpers shared by the AES round linear operations
// block.
// ----------------------------------------------------------------------------
package bcrlo_pkg;

    localparam int OPCODE_W = 3;
    localparam int HALF_W   = 64;
    localparam int NUM_BYTES = 16;

    // Reduction polynomial x^8 + x^4 + x^3 + x + 1 with the carry bit dropped.
    localparam logic [7:0] GF_POLY = 8'h1B;
    localparam logic [7:0] GF_MSB  = 8'h80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_KEY   = 3'd0,
        OP_SHIFT     = 3'd1,
        OP_INV_SHIFT = 3'd2,
        OP_MIX       = 3'd3,
        OP_INV_MIX   = 3'd4
    } t_opcode;

    // Byte i of the block is element i.
    typedef logic [NUM_BYTES-1:0][7:0] t_block;
    typedef logic [3:0][7:0] t_column;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] s;
        s = {a[6:0], 1'b0};
        if ((a & GF_MSB) != 8'h00) begin
            s = s ^ GF_POLY;
        end
        return s;
    endfunction

endpackage : bcrlo_pkg
`default_nettype wire

@@ rtl/bcrlo_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcrlo_in_if
// Input channel: opcode, block and round key with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcrlo_in_if
    import bcrlo_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [HALF_W-1:0]   state_low;
    logic [HALF_W-1:0]   state_high;
    logic [HALF_W-1:0]   round_key_low;
    logic [HALF_W-1:0]   round_key_high;

    modport source (
        output valid, opcode, state_low, state_high, round_key_low, round_key_high,
        input  ready
    );

    modport sink (
        input  valid, opcode, state_low, state_high, round_key_low, round_key_high,
        output ready
    );
endinterface : bcrlo_in_if
`default_nettype wire

@@ rtl/bcrlo_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcrlo_out_if
// Result channel: transformed block with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcrlo_out_if
    import bcrlo_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result_low;
    logic [HALF_W-1:0] result_high;

    modport source (
        output valid, result_low, result_high,
        input  ready
    );

    modport sink (
        input  valid, result_low, result_high,
        output ready
    );
endinterface : bcrlo_out_if
`default_nettype wire

@@ rtl/bcrlo_mix.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcrlo_mix
// One column of MixColumns or InvMixColumns, selected by i_inv.
// ----------------------------------------------------------------------------
module bcrlo_mix
    import bcrlo_pkg::*;
(
    input  wire logic    i_inv,
    input  wire t_column i_col,
    output t_column      o_col
);

    // Per input byte: the product by each circulant coefficient position.
    logic [3:0][3:0][7:0] w_prod;
    logic [3:0][7:0]      w_x2;
    logic [3:0][7:0]      w_x4;
    logic [3:0][7:0]      w_x8;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_x2[k] = gf_xtime(i_col[k]);
            w_x4[k] = gf_xtime(w_x2[k]);
            w_x8[k] = gf_xtime(w_x4[k]);
            if (i_inv) begin
                w_prod[k][0] = w_x8[k] ^ w_x4[k] ^ w_x2[k];      // 14
                w_prod[k][1] = w_x8[k] ^ w_x2[k] ^ i_col[k];     // 11
                w_prod[k][2] = w_x8[k] ^ w_x4[k] ^ i_col[k];     // 13
                w_prod[k][3] = w_x8[k] ^ i_col[k];               // 9
            end else begin
                w_prod[k][0] = w_x2[k];                          // 2
                w_prod[k][1] = w_x2[k] ^ i_col[k];               // 3
                w_prod[k][2] = i_col[k];                         // 1
                w_prod[k][3] = i_col[k];                         // 1
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            o_col[r] = 8'h00;
            for (int k = 0; k < 4; k++) begin
                o_col[r] = o_col[r] ^ w_prod[k][2'(k - r + 4)];
            end
        end
    end

endmodule : bcrlo_mix
`default_nettype wire

@@ rtl/bcrlo_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcrlo_alu
// Combinational datapath: add round key, (inverse) shift rows and (inverse)
// mix columns on one 16-byte block, selected by the opcode.
// ----------------------------------------------------------------------------
module bcrlo_alu
    import bcrlo_pkg::*;
(
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire t_block              i_state,
    input  wire t_block              i_key,
    output t_block                   o_result
);

    t_block w_shift;
    t_block w_inv_shift;
    t_block w_mix;
    logic   w_inv;

    // Column c holds bytes 4c..4c+3; row r is the offset inside the column.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_shift[r + 4 * c]     = i_state[r + 4 * int'(2'(c + r))];
                w_inv_shift[r + 4 * c] = i_state[r + 4 * int'(2'(c + 4 - r))];
            end
        end
    end

    assign w_inv = (i_opcode == OP_INV_MIX);

    for (genvar g = 0; g < 4; g++) begin : g_col
        bcrlo_mix u_mix (
            .i_inv (w_inv),
            .i_col (i_state[4 * g +: 4]),
            .o_col (w_mix[4 * g +: 4])
        );
    end

    // Opcodes without an operation pass the block through.
    always_comb begin
        case (i_opcode)
            OP_ADD_KEY:   o_result = i_state ^ i_key;
            OP_SHIFT:     o_result = w_shift;
            OP_INV_SHIFT: o_result = w_inv_shift;
            OP_MIX:       o_result = w_mix;
            OP_INV_MIX:   o_result = w_mix;
            default:      o_result = i_state;
        endcase
    end

endmodule : bcrlo_alu
`default_nettype wire

@@ rtl/block_cipher_round_linear_ops.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// block_cipher_round_linear_ops
// AES round linear operations with an input register and a result register.
// ----------------------------------------------------------------------------
// One item enters per cycle while input ready is high. An accepted item is
// captured in the input register, the opcode-selected operation (add round
// key, shift rows, inverse shift rows, mix columns or inverse mix columns)
// is computed in one pass of XOR logic, and the result is held in the
// result register until the sink takes it. Unused opcodes pass the block
// through unchanged. The two registers form a stalling pipeline, so a full
// result register does not stop the input register from taking an item;
// input ready falls only when both hold items and the sink is not ready.
// ----------------------------------------------------------------------------
module block_cipher_round_linear_ops
    import bcrlo_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bcrlo_in_if.sink     i_in,
    bcrlo_out_if.source  o_out
);

    logic                r_s1_valid;
    logic                n_s1_valid;
    logic [OPCODE_W-1:0] r_s1_opcode;
    t_block              r_s1_state;
    t_block              r_s1_key;
    logic                r_s2_valid;
    logic                n_s2_valid;
    t_block              r_s2_result;

    t_block w_result;
    logic   w_s2_load;
    logic   w_s1_load;

    assign w_s2_load = !r_s2_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_s2_load;
    assign w_s1_load = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (w_s2_load) begin
            n_s2_valid = r_s1_valid;
        end
        if (i_in.ready) begin
            n_s1_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_opcode <= i_in.opcode;
            r_s1_state  <= {i_in.state_high, i_in.state_low};
            r_s1_key    <= {i_in.round_key_high, i_in.round_key_low};
        end
        if (w_s2_load && r_s1_valid) begin
            r_s2_result <= w_result;
        end
    end

    bcrlo_alu u_alu (
        .i_opcode (r_s1_opcode),
        .i_state  (r_s1_state),
        .i_key    (r_s1_key),
        .o_result (w_result)
    );

    assign o_out.valid       = r_s2_valid;
    assign o_out.result_low  = r_s2_result[NUM_BYTES/2-1:0];
    assign o_out.result_high = r_s2_result[NUM_BYTES-1:NUM_BYTES/2];

endmodule : block_cipher_round_linear_ops
`default_nettype wire

@@ rtl/bcrlo_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcrlo_chk
// Port-level checks for the AES round linear operations block.
// ----------------------------------------------------------------------------
module bcrlo_chk
    import bcrlo_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [HALF_W-1:0] i_result_low,
    input wire logic [HALF_W-1:0] i_result_high
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_result_low) && $stable(i_result_high))
        else $error("stalled result changed");

    // Input is refused only when both stages are full and the sink stalls.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input refused without output back-pressure");

    // A rising result valid traces back to an accepted item through both registers.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without an accepted item");

endmodule : bcrlo_chk

bind block_cipher_round_linear_ops bcrlo_chk u_bcrlo_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_low  (o_out.result_low),
    .i_result_high (o_out.result_high)
);
`default_nettype wire
